[sv/dlw_pkg.sv]
// Shared constants and types for the dispatch loop watchdog.
`default_nettype none
package dlw_pkg;

	localparam int ADDR_W         = 32;
	localparam int ZERO_W         = 16;
	localparam int REPEAT_W       = 24;
	localparam int CFG_DATA_W     = 24;
	localparam int CFG_INDEX_W    = 1;
	localparam int VERDICT_W      = 2;
	localparam int RING_DEPTH_DEF = 16;

	localparam logic [ZERO_W-1:0]   ZERO_LIMIT_RST   = ZERO_W'(64);
	localparam logic [REPEAT_W-1:0] REPEAT_LIMIT_RST = REPEAT_W'(300000);
	localparam logic [ZERO_W-1:0]   ZERO_MAX         = '1;
	localparam logic [REPEAT_W-1:0] REPEAT_MAX       = '1;

	// Trip causes, as shown on verdict
	localparam logic [VERDICT_W-1:0] CAUSE_NONE = 2'd0;
	localparam logic [VERDICT_W-1:0] CAUSE_ZERO = 2'd1;
	localparam logic [VERDICT_W-1:0] CAUSE_LOOP = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LIMIT   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_LIMIT = 1'b1;

	typedef struct packed {
		logic capture;
		logic exec;
	} dlw_cmd_t;

endpackage
`default_nettype wire

[sv/dlw_ctrl.sv]
// Controller state machine: sequences capture, update and result hand-off.
`default_nettype none
module dlw_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire            out_stall,
	output dlw_pkg::dlw_cmd_t cmd
);
	import dlw_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   out_valid_q;

	assign in_stall    = in_stall_q;
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && !in_stall_q;
	assign cmd.exec    = (state_q == ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_EXEC;
						in_stall_q <= 1'b1;
					end
				end
				ST_EXEC: begin
					state_q     <= ST_HOLD;
					out_valid_q <= 1'b1;
				end
				ST_HOLD: begin
					// release the result beat once taken and reopen the input
					if (!out_stall) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
						in_stall_q  <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
					in_stall_q  <= 1'b0;
				end
			endcase
		end
	end

	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec)
		else $error("capture not followed by update");
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid)
		else $error("update not followed by result");
	a_result_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

endmodule
`default_nettype wire

[sv/dlw_datapath.sv]
// Datapath: recent-address ring, counters, trip cause and limit registers.
`default_nettype none
module dlw_datapath #(
	parameter int RING_DEPTH = dlw_pkg::RING_DEPTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire  dlw_pkg::dlw_cmd_t              cmd,
	input  wire                                  cfg_we,
	input  wire  [dlw_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [dlw_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire  [dlw_pkg::ADDR_W-1:0]           dispatch_address,
	input  wire                                  new_run,
	output logic [dlw_pkg::VERDICT_W-1:0]        verdict,
	output logic                                 seen_recently,
	output logic [dlw_pkg::REPEAT_W-1:0]         repeat_streak
);
	import dlw_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic [ADDR_W-1:0]     addr_q;
	logic                  new_run_q;
	logic [ADDR_W-1:0]     ring_q [RING_DEPTH];
	logic [RING_DEPTH-1:0] ring_vld_q;
	logic [PTR_W-1:0]      ptr_q;
	logic [ZERO_W-1:0]     zc_q;
	logic [REPEAT_W-1:0]   rc_q;
	logic [VERDICT_W-1:0]  cause_q;
	logic [ZERO_W-1:0]     zero_limit_q;
	logic [REPEAT_W-1:0]   repeat_limit_q;
	logic [VERDICT_W-1:0]  verdict_q;
	logic                  seen_q;
	logic [REPEAT_W-1:0]   streak_q;

	logic [RING_DEPTH-1:0] vld_eff, vld_next, match;
	logic [PTR_W-1:0]      ptr_eff, ptr_next;
	logic [ZERO_W-1:0]     zc_eff, zc_sat, zc_next;
	logic [REPEAT_W-1:0]   rc_eff, rc_sat, rc_next;
	logic [VERDICT_W-1:0]  cause_eff, cause_next;
	logic                  running, addr_zero, zero_trip, do_lookup, hit;

	// a new run starts from cleared state
	assign vld_eff   = new_run_q ? '0 : ring_vld_q;
	assign ptr_eff   = new_run_q ? '0 : ptr_q;
	assign zc_eff    = new_run_q ? '0 : zc_q;
	assign rc_eff    = new_run_q ? '0 : rc_q;
	assign cause_eff = new_run_q ? CAUSE_NONE : cause_q;

	assign running   = (cause_eff == CAUSE_NONE);
	assign addr_zero = (addr_q == '0);
	assign zc_sat    = (zc_eff == ZERO_MAX) ? zc_eff : zc_eff + 1'b1;
	assign zc_next   = (running && addr_zero) ? zc_sat : zc_eff;
	assign zero_trip = running && addr_zero && (zc_sat >= zero_limit_q);
	assign do_lookup = running && !zero_trip;

	always_comb begin
		for (int k = 0; k < RING_DEPTH; k++) begin
			match[k] = vld_eff[k] && (ring_q[k] == addr_q);
		end
	end

	assign hit     = do_lookup && (|match);
	assign rc_sat  = (rc_eff == REPEAT_MAX) ? rc_eff : rc_eff + 1'b1;
	assign rc_next = do_lookup ? (hit ? rc_sat : '0) : rc_eff;

	always_comb begin
		if (zero_trip) begin
			cause_next = CAUSE_ZERO;
		end else if (hit && (rc_sat >= repeat_limit_q)) begin
			cause_next = CAUSE_LOOP;
		end else begin
			cause_next = cause_eff;
		end
	end

	assign ptr_next = (ptr_eff == PTR_LAST) ? '0 : ptr_eff + 1'b1;

	always_comb begin
		vld_next = vld_eff;
		if (do_lookup) begin
			vld_next[ptr_eff] = 1'b1;
		end
	end

	// input beat capture and ring entries carry no reset
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q    <= dispatch_address;
			new_run_q <= new_run;
		end
		if (cmd.exec && do_lookup) begin
			ring_q[ptr_eff] <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q     <= '0;
			ptr_q          <= '0;
			zc_q           <= '0;
			rc_q           <= '0;
			cause_q        <= CAUSE_NONE;
			zero_limit_q   <= ZERO_LIMIT_RST;
			repeat_limit_q <= REPEAT_LIMIT_RST;
			verdict_q      <= CAUSE_NONE;
			seen_q         <= 1'b0;
			streak_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ZERO_LIMIT:   zero_limit_q   <= cfg_data[ZERO_W-1:0];
					REG_REPEAT_LIMIT: repeat_limit_q <= cfg_data[REPEAT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				ring_vld_q <= vld_next;
				if (do_lookup) begin
					ptr_q <= ptr_next;
				end else begin
					ptr_q <= ptr_eff;
				end
				zc_q      <= zc_next;
				rc_q      <= rc_next;
				cause_q   <= cause_next;
				verdict_q <= cause_next;
				seen_q    <= hit;
				streak_q  <= rc_next;
			end
		end
	end

	assign verdict       = verdict_q;
	assign seen_recently = seen_q;
	assign repeat_streak = streak_q;

	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (streak_q != '0))
		else $error("hit reported with empty streak");
	a_zero_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !new_run_q) |=> (zc_q >= $past(zc_q)))
		else $error("zero counter fell without a new run");
	a_trip_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !new_run_q && (cause_q != CAUSE_NONE)) |=> $stable(cause_q)
		&& $stable(rc_q) && $stable(ring_vld_q))
		else $error("state moved while tripped");

endmodule
`default_nettype wire

[sv/dispatch_loop_watchdog_unit.sv]
// Top level of the dispatch loop watchdog: controller, datapath and ports.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_stall  | dispatch_address, new_run
//  out      | out_valid / out_stall| verdict, seen_recently, repeat_streak
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each item passes through three controller steps: accept, update
// (parallel ring compare and counter step), result beat. The input stays
// stalled from accept until the result beat is taken. Reset clears
// counters, trip cause and ring valid bits; limits return to 64 and
// 300000. Configuration writes are taken every cycle.
`default_nettype none
module dispatch_loop_watchdog_unit #(
	parameter int RING_DEPTH = dlw_pkg::RING_DEPTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [dlw_pkg::ADDR_W-1:0]       dispatch_address,
	input  wire                              new_run,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [dlw_pkg::VERDICT_W-1:0]    verdict,
	output logic                             seen_recently,
	output logic [dlw_pkg::REPEAT_W-1:0]     repeat_streak,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [dlw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [dlw_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dlw_pkg::*;

	dlw_cmd_t cmd;

	assign cfg_ready = 1'b1;

	dlw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dlw_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.dispatch_address (dispatch_address),
		.new_run          (new_run),
		.verdict          (verdict),
		.seen_recently    (seen_recently),
		.repeat_streak    (repeat_streak)
	);

endmodule
`default_nettype wire
